>>> src/b64_pkg.sv
// Shared types, constants and character tables for the base64 codec.
// No dependencies; the front end, queue, back end and top import this package.
package b64_pkg;

    // Pad character emitted for the missing tail of a partial group
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Depth of the job queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // One unit of back-end work: a group of four characters or one decoded byte
    typedef struct packed {
        logic        is_dec;   // decoded byte in grp[7:0]
        logic [23:0] grp;      // 24-bit group, most significant sextet first
        logic [1:0]  nbytes;   // real bytes in the group, 1..3
        logic        eom;      // job ends the message
    } job_t;

    // Queue status seen by the front and the back
    typedef struct packed {
        logic not_empty;
        logic full;
    } q_stat_t;

    // Map a six-bit value to its alphabet character
    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26)
        begin
            c = 8'h41 + {2'b00, v};
        end
        else if (v < 6'd52)
        begin
            c = 8'h61 + {2'b00, v - 6'd26};
        end
        else if (v < 6'd62)
        begin
            c = 8'h30 + {2'b00, v - 6'd52};
        end
        else if (v == 6'd62)
        begin
            c = 8'h2B;
        end
        else
        begin
            c = 8'h2F;
        end
        return c;
    endfunction

    // Map a character to {valid, six-bit value}; valid is low outside the alphabet
    function automatic logic [6:0] dec_char(input logic [7:0] c);
        logic [6:0] r;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = {1'b1, 6'(c - 8'h41)};
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            r = {1'b1, 6'(c - 8'h61 + 8'd26)};
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, 6'(c - 8'h30 + 8'd52)};
        end
        else if (c == 8'h2B)
        begin
            r = {1'b1, 6'd62};
        end
        else if (c == 8'h2F)
        begin
            r = {1'b1, 6'd63};
        end
        else
        begin
            r = 7'd0;
        end
        return r;
    endfunction

endpackage

>>> src/b64_intf.sv
// Valid/ready channel interfaces of the base64 codec: input, output, config.
// No dependencies.
interface b64_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;
    modport source (output valid, data_byte, end_of_message, input ready);
    modport sink (input valid, data_byte, end_of_message, output ready);
endinterface

interface b64_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       message_final;
    modport source (output valid, out_byte, run_last, message_final, input ready);
    modport sink (input valid, out_byte, run_last, message_final, output ready);
endinterface

interface b64_cfg_if;
    logic valid;
    logic ready;
    logic decode_mode;
    modport source (output valid, decode_mode, input ready);
    modport sink (input valid, decode_mode, output ready);
endinterface

>>> src/b64_front.sv
// Front end: accepts items, keeps encoder/decoder state, turns items into jobs.
// Depends on b64_pkg and the channel interfaces in b64_intf.sv.
module b64_front
    import b64_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    b64_in_if.sink    in_ch,
    b64_cfg_if.sink   cfg_ch,
    input  q_stat_t   q_stat,
    output logic      push,
    output job_t      push_job
);

    logic        mode_reg;
    logic [15:0] held_bytes_reg, held_bytes_next;
    logic [1:0]  held_count_reg, held_count_next;
    logic [11:0] acc_reg, acc_next;
    logic [2:0]  bit_count_reg, bit_count_next;

    logic        accept;
    logic [7:0]  byte_in;
    logic        eom;
    logic [6:0]  dv;
    logic [3:0]  bit_sum;
    logic [11:0] acc_shift;
    logic [11:0] acc_sel;

    // Accept while the queue has room; config is always taken
    assign in_ch.ready  = !q_stat.full;
    assign cfg_ch.ready = 1'b1;
    assign accept       = in_ch.valid && in_ch.ready;
    assign byte_in      = in_ch.data_byte;
    assign eom          = in_ch.end_of_message;
    assign dv           = dec_char(byte_in);

    // Mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_ch.valid)
        begin
            mode_reg <= cfg_ch.decode_mode;
        end
    end

    // Classify the item and compute next state
    always_comb
    begin
        held_bytes_next = held_bytes_reg;
        held_count_next = held_count_reg;
        acc_next        = acc_reg;
        bit_count_next  = bit_count_reg;
        push            = 1'b0;
        push_job        = '{is_dec: mode_reg, grp: 24'd0, nbytes: 2'd3, eom: eom};
        bit_sum         = {1'b0, bit_count_reg} + 4'd6;
        acc_shift       = {acc_reg[5:0], dv[5:0]};
        acc_sel         = 12'd0;
        if (accept)
        begin
            if (!mode_reg)
            begin
                if (held_count_reg == 2'd2)
                begin
                    push            = 1'b1;
                    push_job.grp    = {held_bytes_reg, byte_in};
                    push_job.nbytes = 2'd3;
                    held_bytes_next = 16'd0;
                    held_count_next = 2'd0;
                end
                else
                begin
                    held_bytes_next = {held_bytes_reg[7:0], byte_in};
                    held_count_next = held_count_reg + 2'd1;
                    if (eom)
                    begin
                        push = 1'b1;
                        if (held_count_reg == 2'd0)
                        begin
                            push_job.grp    = {byte_in, 16'd0};
                            push_job.nbytes = 2'd1;
                        end
                        else
                        begin
                            push_job.grp    = {held_bytes_reg[7:0], byte_in, 8'd0};
                            push_job.nbytes = 2'd2;
                        end
                        held_bytes_next = 16'd0;
                        held_count_next = 2'd0;
                    end
                end
            end
            else
            begin
                if (dv[6])
                begin
                    acc_next = acc_shift;
                    if (bit_sum >= 4'd8)
                    begin
                        bit_count_next    = 3'(bit_sum - 4'd8);
                        acc_sel           = acc_shift >> bit_count_next;
                        push              = 1'b1;
                        push_job.grp      = {16'd0, acc_sel[7:0]};
                    end
                    else
                    begin
                        bit_count_next = bit_sum[2:0];
                    end
                end
                if (eom)
                begin
                    acc_next       = 12'd0;
                    bit_count_next = 3'd0;
                end
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_bytes_reg <= 16'd0;
            held_count_reg <= 2'd0;
            acc_reg        <= 12'd0;
            bit_count_reg  <= 3'd0;
        end
        else
        begin
            held_bytes_reg <= held_bytes_next;
            held_count_reg <= held_count_next;
            acc_reg        <= acc_next;
            bit_count_reg  <= bit_count_next;
        end
    end

`ifndef SYNTHESIS
    // Decoder keeps an even bit count of at most six between items
    a_bit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (bit_count_reg[0] == 1'b0) && (bit_count_reg <= 3'd6))
        else $error("decoder bit count out of range");
    // Encoder never holds a full group
    a_held_count: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg != 2'd3)
        else $error("encoder holds three bytes");
`endif

endmodule

>>> src/b64_queue.sv
// Short job queue between the front end and the back end.
// Depends on b64_pkg.
module b64_queue
    import b64_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  job_t    push_job,
    input  logic    pop,
    output job_t    head_job,
    output q_stat_t q_stat
);

    job_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;

    assign head_job         = mem_reg[rd_ptr_reg];
    assign q_stat.not_empty = count_reg != '0;
    assign q_stat.full      = count_reg == Q_CNT_W'(Q_DEPTH);

    // Store a pushed job
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    // No push into a full queue, no pop from an empty one
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_stat.full))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !q_stat.not_empty))
        else $error("pop from empty queue");
`endif

endmodule

>>> src/b64_back.sv
// Back end: expands queued jobs into result items through an output register.
// Depends on b64_pkg and the output interface in b64_intf.sv.
module b64_back
    import b64_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  job_t      head_job,
    input  q_stat_t   q_stat,
    output logic      pop,
    b64_out_if.source out_ch
);

    logic       out_valid_reg;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       run_last_reg, run_last_next;
    logic       final_reg, final_next;
    logic [1:0] pos_reg, pos_next;
    logic       load;
    logic       last;

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.out_byte      = out_byte_reg;
    assign out_ch.run_last      = run_last_reg;
    assign out_ch.message_final = final_reg;

    // Load a new result whenever the output register is free or being taken
    assign load = q_stat.not_empty && (!out_valid_reg || out_ch.ready);
    assign last = head_job.is_dec || (pos_reg == 2'd3);
    assign pop  = load && last;

    // Pick the character or byte for the current position
    always_comb
    begin
        pos_next = last ? 2'd0 : pos_reg + 2'd1;
        if (head_job.is_dec)
        begin
            out_byte_next = head_job.grp[7:0];
        end
        else
        begin
            case (pos_reg)
                2'd0: out_byte_next = enc_char(head_job.grp[23:18]);
                2'd1: out_byte_next = enc_char(head_job.grp[17:12]);
                2'd2: out_byte_next = (head_job.nbytes >= 2'd2) ?
                                      enc_char(head_job.grp[11:6]) : PAD_CHAR;
                2'd3: out_byte_next = (head_job.nbytes == 2'd3) ?
                                      enc_char(head_job.grp[5:0]) : PAD_CHAR;
                default: out_byte_next = PAD_CHAR;
            endcase
        end
        run_last_next = last;
        final_next    = last && head_job.eom;
    end

    // Control: output valid and position within the job
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pos_reg       <= 2'd0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                pos_reg       <= pos_next;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the output register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= out_byte_next;
            run_last_reg <= run_last_next;
            final_reg    <= final_next;
        end
    end

`ifndef SYNTHESIS
    // Mid-group position only while an encode job waits at the queue head
    a_pos_job: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg != 2'd0) |-> (q_stat.not_empty && !head_job.is_dec))
        else $error("group position without encode job");
    // Message end is always flagged on a run's last item
    a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && final_reg) |-> run_last_reg)
        else $error("message end on a non-final item");
`endif

endmodule

>>> src/base64_codec_top.sv
// Top level of the streaming base64 codec: front end, job queue, back end.
// Depends on b64_pkg, b64_intf.sv, b64_front, b64_queue and b64_back.
//
//  Channel  | Dir | Payload                                  | Handshake
//  in_ch    | in  | data_byte[7:0], end_of_message           | valid/ready
//  out_ch   | out | out_byte[7:0], run_last, message_final   | valid/ready
//  cfg_ch   | in  | decode_mode                              | valid/ready (ready tied high)
//
// Decode: one item per cycle while the queue has room; a byte goes through the job
// queue into the output register. Encode: the four characters of a three-byte group
// leave one per cycle while the output is ready, so the output port sets the encode
// rate. A two-job queue lets the front take items while the back stalls. Reset
// clears control and codec state at once, not queue/output data; no clearing pass.
module base64_codec_top
    import b64_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    b64_in_if.sink    in_ch,
    b64_out_if.source out_ch,
    b64_cfg_if.sink   cfg_ch
);

    logic    push;
    logic    pop;
    job_t    push_job;
    job_t    head_job;
    q_stat_t q_stat;

    // Classify items into jobs
    b64_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .cfg_ch   (cfg_ch),
        .q_stat   (q_stat),
        .push     (push),
        .push_job (push_job)
    );

    // Hold pending jobs
    b64_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_stat   (q_stat)
    );

    // Expand jobs into result items
    b64_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_job (head_job),
        .q_stat   (q_stat),
        .pop      (pop),
        .out_ch   (out_ch)
    );

endmodule

>>> sim/tb_base64_codec_top.sv
`timescale 1ns / 100ps
// Testbench for base64_codec_top: directed and random encode/decode traffic with a
// self-checking predictor of the codec. Depends on the b64_intf.sv interfaces and the RTL.
module tb_base64_codec_top;

    // Register values
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam logic [8*64-1:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam logic [7:0] PAD_EQ = "=";

    // Cycles the block may still be busy after its last result
    localparam int DRAIN_CYCLES = 10;
    localparam int RANDOM_ITEMS = 90;
    localparam int PHASE_ITEMS = 15;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       message_final;
    } codec_result_t;

    logic clk = 1'b0;
    logic rst_n;

    b64_in_if  in_ch ();
    b64_out_if out_ch ();
    b64_cfg_if cfg_ch ();

    base64_codec_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    // Predictor state: mode, encoder byte buffer, decoder bit accumulator
    logic          cur_mode;
    logic [15:0]   enc_held;
    logic [1:0]    enc_count;
    logic [11:0]   dec_acc;
    int            dec_bits;
    logic [7:0]    staged[$];
    codec_result_t awaited_outputs[$];
    codec_result_t head_result;

    int mismatches;
    bit in_idle;
    bit out_idle;
    int stall_left;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Generous overall limit
    initial
    begin
        #400000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [7:0] alphabet_char(input logic [5:0] v);
        return B64_ALPHABET[8*(63 - v) +: 8];
    endfunction

    // Position of a character in the alphabet, -1 if absent
    function automatic int sextet_of(input logic [7:0] c);
        int i;
        for (i = 0; i < 64; i++)
        begin
            if (B64_ALPHABET[8*(63 - i) +: 8] == c)
                return i;
        end
        return -1;
    endfunction

    // Stage the four characters of one group; missing bytes become pad
    task automatic stage_group(input logic [23:0] grp, input int real_bytes);
        staged = {staged, alphabet_char(grp[23:18])};
        staged = {staged, alphabet_char(grp[17:12])};
        staged = {staged, (real_bytes >= 2 ? alphabet_char(grp[11:6]) : PAD_EQ)};
        staged = {staged, (real_bytes >= 3 ? alphabet_char(grp[5:0]) : PAD_EQ)};
    endtask

    // Advance the predictor by one accepted item and queue its results
    task automatic compute_codec_output(input logic [7:0] b, input logic eom);
        int            v;
        logic [11:0]   shifted;
        codec_result_t r;
        staged.delete();
        if (cur_mode == MODE_ENCODE)
        begin
            if (enc_count == 2'd2)
            begin
                stage_group({enc_held, b}, 3);
                enc_held = '0;
                enc_count = '0;
            end
            else
            begin
                enc_held = {enc_held[7:0], b};
                enc_count = enc_count + 2'd1;
            end
            // Flush a partial group at end of message
            if (eom)
            begin
                if (enc_count == 2'd1)
                    stage_group({enc_held[7:0], 16'h0000}, 1);
                else if (enc_count == 2'd2)
                    stage_group({enc_held, 8'h00}, 2);
                enc_held = '0;
                enc_count = '0;
            end
        end
        else
        begin
            v = sextet_of(b);
            if (v >= 0)
            begin
                dec_acc = {dec_acc[5:0], v[5:0]};
                dec_bits = dec_bits + 6;
                if (dec_bits >= 8)
                begin
                    dec_bits = dec_bits - 8;
                    shifted = dec_acc >> dec_bits;
                    staged = {staged, shifted[7:0]};
                end
            end
            // Drop leftover bits at end of message
            if (eom)
            begin
                dec_acc = '0;
                dec_bits = 0;
            end
        end
        foreach (staged[i])
        begin
            r.out_byte = staged[i];
            r.run_last = (i == staged.size() - 1);
            r.message_final = r.run_last && eom;
            awaited_outputs = {awaited_outputs, r};
        end
    endtask

    // Send one item, after a random gap when input idling is on; predict it once accepted
    task automatic send_item(input logic [7:0] b, input logic eom);
        int gap;
        gap = in_idle ? $urandom_range(0, 15) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge clk);
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.end_of_message <= eom;
        do
            @(posedge clk);
        while (!in_ch.ready);
        compute_codec_output(b, eom);
    endtask

    // Hold input until every awaited result has come and the block is quiet
    task automatic drain_results();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (awaited_outputs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic mode);
        drain_results();
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.decode_mode <= mode;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cur_mode = mode;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Full group ending a message, one-byte and two-byte tails, byte extremes
    task automatic test_encode_groups();
        in_idle = 1'b1;
        out_idle = 1'b1;
        write_mode(MODE_ENCODE);
        send_item("M", 1'b0);
        send_item("a", 1'b0);
        send_item("n", 1'b1);
        send_item(8'hFF, 1'b1);
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b1);
    endtask

    // Alphabet range edges, skipped characters, end of message with no byte out
    task automatic test_decode_chars();
        write_mode(MODE_DECODE);
        send_item("A", 1'b0);
        send_item("Z", 1'b0);
        send_item(8'hFF, 1'b0);
        send_item("a", 1'b0);
        send_item("z", 1'b0);
        send_item("[", 1'b0);
        send_item("0", 1'b0);
        send_item("9", 1'b0);
        send_item(8'h00, 1'b0);
        send_item("+", 1'b0);
        send_item("{", 1'b0);
        send_item("/", 1'b1);
        send_item("/", 1'b0);
        send_item("w", 1'b0);
        send_item(PAD_EQ, 1'b0);
        send_item(PAD_EQ, 1'b1);
    endtask

    // Each direction keeps its partial state across a mode change
    task automatic test_mode_switch();
        write_mode(MODE_ENCODE);
        send_item(8'hA5, 1'b0);
        write_mode(MODE_DECODE);
        send_item("Q", 1'b0);
        write_mode(MODE_ENCODE);
        send_item(8'h5A, 1'b0);
        send_item(8'hC3, 1'b1);
        write_mode(MODE_DECODE);
        send_item("w", 1'b1);
    endtask

    // Random messages in phases that vary mode and idling on both sides
    task automatic test_random_messages();
        int         counted;
        int         phase;
        int         phase_count;
        int         msg_len;
        int         i;
        int         pick;
        bit         keep_open;
        logic [7:0] c;
        logic       eom;
        counted = 0;
        phase = 0;
        while (counted < RANDOM_ITEMS)
        begin
            write_mode((phase % 2 == 1) ^ ((phase / 4) % 2 == 1) ? MODE_DECODE : MODE_ENCODE);
            in_idle = (phase % 4) < 2;
            out_idle = (phase % 2) == 0;
            phase_count = 0;
            while (phase_count < PHASE_ITEMS)
            begin
                msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 24)
                                                      : $urandom_range(1, 8);
                // Leave some messages open to carry state forward
                keep_open = ($urandom_range(0, 7) == 0);
                for (i = 0; i < msg_len; i++)
                begin
                    eom = (i == msg_len - 1) && !keep_open;
                    pick = $urandom_range(0, 255);
                    if (cur_mode == MODE_ENCODE)
                        c = pick[7:0];
                    else if ($urandom_range(0, 9) == 0)
                        c = $urandom_range(0, 1) ? PAD_EQ : pick[7:0];
                    else
                        c = alphabet_char(pick[5:0]);
                    send_item(c, eom);
                    if (cur_mode == MODE_ENCODE || sextet_of(c) >= 0)
                        phase_count++;
                end
            end
            counted += phase_count;
            phase++;
        end
    endtask

    // Drop ready for the drawn stall after each result
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ch.ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
            out_ch.ready <= 1'b1;
    end

    // Compare each result with the oldest awaited one
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            stall_left = out_idle ? $urandom_range(0, 15) : 0;
            if (awaited_outputs.size() == 0)
            begin
                $error("out_byte: result %h arrived with none awaited", out_ch.out_byte);
                mismatches++;
            end
            else
            begin
                head_result = awaited_outputs.pop_front();
                if (out_ch.out_byte !== head_result.out_byte)
                begin
                    $error("out_byte: expected %h, got %h", head_result.out_byte,
                           out_ch.out_byte);
                    mismatches++;
                end
                if (out_ch.run_last !== head_result.run_last)
                begin
                    $error("run_last: expected %b, got %b", head_result.run_last,
                           out_ch.run_last);
                    mismatches++;
                end
                if (out_ch.message_final !== head_result.message_final)
                begin
                    $error("message_final: expected %b, got %b", head_result.message_final,
                           out_ch.message_final);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        mismatches = 0;
        stall_left = 0;
        in_idle = 1'b0;
        out_idle = 1'b0;
        cur_mode = MODE_ENCODE;
        enc_held = '0;
        enc_count = '0;
        dec_acc = '0;
        dec_bits = 0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.end_of_message = 1'b0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.decode_mode = MODE_ENCODE;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_encode_groups();
        test_decode_chars();
        test_mode_switch();
        test_random_messages();

        drain_results();
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> filelist.f
src/b64_pkg.sv
src/b64_intf.sv
src/b64_front.sv
src/b64_queue.sv
src/b64_back.sv
src/base64_codec_top.sv
sim/tb_base64_codec_top.sv
